// ----- rtl/core/lgs_pkg.sv -----
// shared constants, op codes and types for the life grid generation step unit
// no dependencies; imported by every module of the block
package lgs_pkg;

  localparam int GRID_COLS = 64;
  localparam int GRID_ROWS = 64;

  localparam int ROW_AW = $clog2(GRID_ROWS);
  localparam int COL_AW = $clog2(GRID_COLS);
  // sweep counter runs 0 .. GRID_ROWS + 1
  localparam int CNT_W  = $clog2(GRID_ROWS + 2);

  localparam int BIRTH_CNT   = 3;
  localparam int SURVIVE_CNT = 2;

  typedef logic [1:0] op_t;

  localparam op_t OP_TOGGLE = 2'd0;
  localparam op_t OP_STEP   = 2'd1;
  localparam op_t OP_READ   = 2'd2;

  typedef logic [GRID_COLS-1:0] row_t;

  typedef struct packed {
    logic              re;
    logic [ROW_AW-1:0] raddr;
    logic              we;
    logic [ROW_AW-1:0] waddr;
    row_t              wdata;
  } mem_req_t;

endpackage

// ----- rtl/core/life_grid_generation_step_unit.sv -----
// Game of life (B3/S23) on a bounded GRID_ROWS x GRID_COLS grid, all dead after reset.
// An item is accepted only while the unit is idle; it then gives exactly one result item.
// A toggle or read of an in-grid cell reads its row, checks it (writing the toggled row
// back) and registers the result before it shows. A generation step sweeps the row memory
// one row per cycle through a three-row window and the shared row rule unit, then reads
// back the addressed cell the same way if it lies in the grid. Out-of-grid toggles and
// reads and the unused op code go straight to the finish state. The next item is taken in the
// cycle the result shows; a result still stalled at the output holds the unit until it leaves.
module life_grid_generation_step_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  lgs_pkg::op_t op_i,
  input  logic [5:0]   row_i,
  input  logic [5:0]   col_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output logic         alive_o,
  output logic         done_res_o
);
  import lgs_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_STEP = 3'd1;
  localparam logic [2:0] ST_RD   = 3'd2;
  localparam logic [2:0] ST_CHK  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  op_t              op_q;
  logic [5:0]       row_q, col_q;
  logic             in_grid_q;
  row_t             above_q, center_q;
  logic             res_alive_q, res_alive_d, res_done_q, res_done_d;
  logic             alive_q, done_q;

  logic             in_acc, in_grid;
  logic [ROW_AW+5:0] row_ext;
  logic [COL_AW+5:0] col_ext;
  logic [ROW_AW-1:0] row_idx;
  logic [COL_AW-1:0] col_idx;
  logic [CNT_W-1:0]  cnt_m2;
  row_t              rd_row, row_in, new_row, tgl_row;
  mem_req_t          mreq;
  logic              cur_bit, fin_go;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign in_grid    = (32'(row_i) < GRID_ROWS) && (32'(col_i) < GRID_COLS);

  assign row_ext = {{ROW_AW{1'b0}}, row_q};
  assign col_ext = {{COL_AW{1'b0}}, col_q};
  assign row_idx = row_ext[ROW_AW-1:0];
  assign col_idx = col_ext[COL_AW-1:0];
  assign cnt_m2  = cnt_q - CNT_W'(2);

  assign cur_bit = rd_row[col_idx];
  assign tgl_row = rd_row ^ (row_t'(1) << col_idx);
  assign fin_go  = !out_valid_q || out_ready_i;

  // rows past the bottom edge feed in as dead
  assign row_in = ((cnt_q != '0) && (cnt_q <= CNT_W'(GRID_ROWS))) ? rd_row : '0;

  lgs_grid_mem u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (mreq),
    .rdata_o (rd_row)
  );

  lgs_row_unit u_rule (
    .above_i  (above_q),
    .center_i (center_q),
    .below_i  (row_in),
    .next_o   (new_row)
  );

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    res_alive_d = res_alive_q;
    res_done_d  = res_done_q;
    mreq        = '0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          cnt_d       = '0;
          res_alive_d = 1'b0;
          res_done_d  = 1'b0;
          if (op_i == OP_STEP) begin
            state_d = ST_STEP;
          end else if (in_grid && (op_i == OP_TOGGLE || op_i == OP_READ)) begin
            state_d = ST_RD;
          end else begin
            state_d = ST_FIN;
          end
        end
      end
      ST_STEP: begin
        // read row cnt, write new row cnt-2 (old copy already in window)
        mreq.re    = (cnt_q < CNT_W'(GRID_ROWS));
        mreq.raddr = cnt_q[ROW_AW-1:0];
        mreq.we    = (cnt_q >= CNT_W'(2));
        mreq.waddr = cnt_m2[ROW_AW-1:0];
        mreq.wdata = new_row;
        cnt_d      = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(GRID_ROWS + 1)) begin
          if (in_grid_q) begin
            state_d = ST_RD;
          end else begin
            res_done_d = 1'b1;
            state_d    = ST_FIN;
          end
        end
      end
      ST_RD: begin
        mreq.re    = 1'b1;
        mreq.raddr = row_idx;
        state_d    = ST_CHK;
      end
      ST_CHK: begin
        res_done_d = 1'b1;
        if (op_q == OP_TOGGLE) begin
          mreq.we     = 1'b1;
          mreq.waddr  = row_idx;
          mreq.wdata  = tgl_row;
          res_alive_d = !cur_bit;
        end else begin
          res_alive_d = cur_bit;
        end
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (fin_go) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_alive_q <= res_alive_d;
    res_done_q  <= res_done_d;
    if (in_acc) begin
      op_q      <= op_i;
      row_q     <= row_i;
      col_q     <= col_i;
      in_grid_q <= in_grid;
      above_q   <= '0;
      center_q  <= '0;
    end else if (state_q == ST_STEP) begin
      above_q  <= center_q;
      center_q <= row_in;
    end
    if (state_q == ST_FIN && fin_go) begin
      alive_q <= res_alive_q;
      done_q  <= res_done_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign alive_o     = alive_q;
  assign done_res_o  = done_q;

endmodule

// ----- rtl/core/lgs_grid_mem.sv -----
// grid row storage: one write and one registered read per cycle
// per-row valid bits make never-written rows read as all dead; uses lgs_pkg
module lgs_grid_mem (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lgs_pkg::mem_req_t req_i,
  output lgs_pkg::row_t     rdata_o
);
  import lgs_pkg::*;

  row_t                 mem [GRID_ROWS];
  logic [GRID_ROWS-1:0] vld_q;
  row_t                 rdata_q;
  logic                 rvld_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (req_i.we) begin
        vld_q[req_i.waddr] <= 1'b1;
      end
      if (req_i.re) begin
        rvld_q <= vld_q[req_i.raddr];
      end
    end
  end

  assign rdata_o = rvld_q ? rdata_q : '0;

endmodule

// ----- rtl/core/lgs_row_unit.sv -----
// next-generation rule for one grid row from the old rows above, at and below
// purely combinational, reused once per swept row; uses lgs_pkg
module lgs_row_unit (
  input  lgs_pkg::row_t above_i,
  input  lgs_pkg::row_t center_i,
  input  lgs_pkg::row_t below_i,
  output lgs_pkg::row_t next_o
);
  import lgs_pkg::*;

  // one dead cell of padding at each edge
  logic [GRID_COLS+1:0] pa, pc, pb;
  logic [3:0]           nbr [GRID_COLS];

  assign pa = {1'b0, above_i, 1'b0};
  assign pc = {1'b0, center_i, 1'b0};
  assign pb = {1'b0, below_i, 1'b0};

  always_comb begin
    for (int c = 0; c < GRID_COLS; c++) begin
      nbr[c] = 4'(pa[c]) + 4'(pa[c+1]) + 4'(pa[c+2])
             + 4'(pc[c]) + 4'(pc[c+2])
             + 4'(pb[c]) + 4'(pb[c+1]) + 4'(pb[c+2]);
      next_o[c] = (nbr[c] == 4'(BIRTH_CNT))
               || ((nbr[c] == 4'(SURVIVE_CNT)) && center_i[c]);
    end
  end

endmodule

// ----- rtl/core/lgs_checker.sv -----
// port-level checks for the life grid generation step unit, bound to the top level
// depends on lgs_pkg and life_grid_generation_step_unit
module lgs_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         in_valid_i,
  input logic         in_ready_o,
  input lgs_pkg::op_t op_i,
  input logic         out_valid_o,
  input logic         out_ready_i,
  input logic         alive_o,
  input logic         done_res_o
);
  import lgs_pkg::*;

  // result holds while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(alive_o) && $stable(done_res_o))
    else $error("result changed while stalled");

  // one item at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("new item taken right after accept");

  // a generation sweep keeps the unit busy longer than a_busy_after_accept checks
  a_step_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && op_i == OP_STEP |=> ##1 !in_ready_o)
    else $error("step finished too early");

  // a live report only comes with a completed operation
  a_alive_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !done_res_o |-> !alive_o)
    else $error("alive set on an incomplete operation");

endmodule

bind life_grid_generation_step_unit lgs_checker u_lgs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .op_i        (op_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .alive_o     (alive_o),
  .done_res_o  (done_res_o)
);

// ----- test/testbench.sv -----
// testbench for life_grid_generation_step_unit: directed and random toggle, step, read and unused-op items
// predicts every result from its own copy of the grid; depends on lgs_pkg and the rtl only
`timescale 1ns / 100ps

module testbench;
  import lgs_pkg::*;

  localparam op_t OP_UNUSED = 2'd3;
  localparam int  RANDOM_ITEMS = 750;
  localparam int  STALL_LIMIT = 2000;
  localparam int  DRAIN_CYCLES = 100;

  typedef struct packed {
    op_t        op;
    logic [5:0] row;
    logic [5:0] col;
    logic       no_gap;
    logic       wait_drain;
  } grid_cmd_t;

  typedef struct packed {
    logic alive;
    logic done_res;
  } cell_result_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  op_t        op_i = OP_TOGGLE;
  logic [5:0] row_i = '0;
  logic [5:0] col_i = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic       alive_o;
  logic       done_res_o;

  grid_cmd_t    cmd_q[$];
  cell_result_t result_q[$];
  row_t         life_grid[GRID_ROWS];
  grid_cmd_t    cur_cmd;
  int           mismatch_cnt = 0;
  int           items_sent = 0;
  int           results_seen = 0;
  int           tx_gap = 0;
  int           rx_stall = 0;
  bit           rx_calm = 1'b0;
  bit           gen_calm = 1'b0;
  int           idle_cycles = 0;

  life_grid_generation_step_unit i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .op_i       (op_i),
    .row_i      (row_i),
    .col_i      (col_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .alive_o    (alive_o),
    .done_res_o (done_res_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatch_cnt++;
  endtask

  // ---------------------------------------------------------------- grid predictor

  function automatic logic cell_live(int r, int c);
    if (r < 0 || r >= GRID_ROWS || c < 0 || c >= GRID_COLS) return 1'b0;
    return life_grid[r][c];
  endfunction

  task automatic advance_life();
    row_t next_gen[GRID_ROWS];
    int   n;
    for (int r = 0; r < GRID_ROWS; r++) begin
      next_gen[r] = '0;
      for (int c = 0; c < GRID_COLS; c++) begin
        n = 0;
        for (int dr = -1; dr <= 1; dr++) begin
          for (int dc = -1; dc <= 1; dc++) begin
            if (dr != 0 || dc != 0) n += cell_live(r + dr, c + dc);
          end
        end
        next_gen[r][c] = (n == BIRTH_CNT) || (n == SURVIVE_CNT && life_grid[r][c]);
      end
    end
    life_grid = next_gen;
  endtask

  task automatic predict_cell(grid_cmd_t cmd);
    cell_result_t res;
    logic         in_grid;
    res = '0;
    in_grid = (int'(cmd.row) < GRID_ROWS) && (int'(cmd.col) < GRID_COLS);
    case (cmd.op)
      OP_TOGGLE: begin
        if (in_grid) begin
          life_grid[cmd.row][cmd.col] = ~life_grid[cmd.row][cmd.col];
          res.alive = life_grid[cmd.row][cmd.col];
          res.done_res = 1'b1;
        end
      end
      OP_STEP: begin
        advance_life();
        if (in_grid) res.alive = life_grid[cmd.row][cmd.col];
        res.done_res = 1'b1;
      end
      OP_READ: begin
        if (in_grid) begin
          res.alive = life_grid[cmd.row][cmd.col];
          res.done_res = 1'b1;
        end
      end
      default: ;
    endcase
    result_q.insert(result_q.size(), res);
  endtask

  // ---------------------------------------------------------------- stimulus

  task automatic add_cmd(op_t op, int r, int c, bit drain = 1'b0);
    grid_cmd_t cmd;
    if ($urandom_range(0, 29) == 0) gen_calm = !gen_calm;
    cmd.op = op;
    cmd.row = r[5:0];
    cmd.col = c[5:0];
    cmd.no_gap = gen_calm;
    cmd.wait_drain = drain || ($urandom_range(0, 59) == 0);
    cmd_q.insert(cmd_q.size(), cmd);
  endtask

  // region origin biased toward the grid borders, where the non-wrapping rule matters
  function automatic int edge_base(int span, int extent);
    int sel;
    sel = $urandom_range(0, 2);
    if (sel == 0) return 0;
    if (sel == 1) return extent - span;
    return $urandom_range(0, extent - span);
  endfunction

  task automatic gen_random_items(int count);
    int stop_at, sel, span, br, bc;
    stop_at = cmd_q.size() + count;
    while (cmd_q.size() < stop_at) begin
      sel = $urandom_range(0, 19);
      if (sel < 12) begin
        // seed a small cluster, then let it evolve and probe it
        span = $urandom_range(3, 8);
        br = edge_base(span, GRID_ROWS);
        bc = edge_base(span, GRID_COLS);
        repeat ($urandom_range(3, span * span / 2))
          add_cmd(OP_TOGGLE, br + $urandom_range(0, span - 1), bc + $urandom_range(0, span - 1));
        repeat ($urandom_range(1, 4)) begin
          add_cmd(OP_STEP, br + $urandom_range(0, span - 1), bc + $urandom_range(0, span - 1));
          repeat ($urandom_range(0, 3))
            add_cmd(OP_READ, br + $urandom_range(0, span - 1), bc + $urandom_range(0, span - 1));
        end
      end else if (sel < 15) begin
        repeat ($urandom_range(1, 4))
          add_cmd(op_t'($urandom_range(0, 3)), $urandom_range(0, 63), $urandom_range(0, 63));
      end else if (sel < 18) begin
        repeat ($urandom_range(1, 3))
          add_cmd(OP_READ, $urandom_range(0, 63), $urandom_range(0, 63));
      end else begin
        add_cmd(OP_STEP, $urandom_range(0, 63), $urandom_range(0, 63));
      end
    end
  endtask

  initial begin
    for (int r = 0; r < GRID_ROWS; r++) life_grid[r] = '0;

    // empty grid, then lone cells in all four corners that die on the next generation
    add_cmd(OP_READ, 0, 0);
    add_cmd(OP_TOGGLE, 0, 0);
    add_cmd(OP_TOGGLE, 0, 63);
    add_cmd(OP_TOGGLE, 63, 0);
    add_cmd(OP_TOGGLE, 63, 63);
    add_cmd(OP_READ, 63, 63);
    add_cmd(OP_STEP, 0, 0, 1'b1);
    add_cmd(OP_READ, 0, 63);
    // blinker on the top border loses its outer cell
    add_cmd(OP_TOGGLE, 0, 30);
    add_cmd(OP_TOGGLE, 0, 31);
    add_cmd(OP_TOGGLE, 0, 32);
    add_cmd(OP_STEP, 1, 31);
    add_cmd(OP_READ, 0, 31);
    // still block in the bottom right corner
    add_cmd(OP_TOGGLE, 62, 62);
    add_cmd(OP_TOGGLE, 62, 63);
    add_cmd(OP_TOGGLE, 63, 62);
    add_cmd(OP_TOGGLE, 63, 63);
    add_cmd(OP_STEP, 63, 63);
    // unused op code changes nothing
    add_cmd(OP_UNUSED, 63, 63);
    add_cmd(OP_UNUSED, 0, 0);
    add_cmd(OP_READ, 62, 62);
    // double toggle restores the cell
    add_cmd(OP_TOGGLE, 31, 0);
    add_cmd(OP_TOGGLE, 31, 0);
    add_cmd(OP_STEP, 0, 63, 1'b1);

    gen_random_items(RANDOM_ITEMS);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (cmd_q.size() != 0 || in_valid_i || items_sent != results_seen) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (result_q.size() != 0) report_mismatch("results still pending at end of run");
    if (mismatch_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // ---------------------------------------------------------------- driver

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      op_i <= OP_TOGGLE;
      row_i <= '0;
      col_i <= '0;
      tx_gap = 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predict_cell(cur_cmd);
        items_sent++;
        tx_gap = cur_cmd.no_gap ? 0 : $urandom_range(0, 14);
      end
      if (!in_valid_i || in_ready_o) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid_i <= 1'b0;
        end else if (cmd_q.size() != 0 &&
                     !(cmd_q[0].wait_drain && items_sent != results_seen)) begin
          cur_cmd = cmd_q.pop_front();
          in_valid_i <= 1'b1;
          op_i <= cur_cmd.op;
          row_i <= cur_cmd.row;
          col_i <= cur_cmd.col;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  task automatic check_result();
    cell_result_t want;
    if (result_q.size() == 0) begin
      report_mismatch("result item with nothing pending");
    end else begin
      want = result_q.pop_front();
      if (alive_o !== want.alive)
        report_mismatch($sformatf("alive %b, predicted %b", alive_o, want.alive));
      if (done_res_o !== want.done_res)
        report_mismatch($sformatf("done_res %b, predicted %b", done_res_o, want.done_res));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      results_seen <= 0;
      rx_stall = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        results_seen <= results_seen + 1;
        check_result();
        if ($urandom_range(0, 24) == 0) rx_calm = !rx_calm;
        rx_stall = rx_calm ? 0 : $urandom_range(0, 14);
      end
      if (rx_stall > 0) begin
        rx_stall--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // no item moving on either side for too long means the block hung
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog: no item accepted for %0d cycles", idle_cycles);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

endmodule

// ----- filelist.f -----
rtl/core/lgs_pkg.sv
rtl/core/lgs_grid_mem.sv
rtl/core/lgs_row_unit.sv
rtl/core/life_grid_generation_step_unit.sv
rtl/core/lgs_checker.sv
test/testbench.sv
